FILE: src/thrl_pkg.sv
// Package with shared constants, request codes, sequencer states and the result record.
`default_nettype none

package thrl_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int LIVE_W  = $clog2(DEPTH + 1);
   localparam int TICK_W  = 32;
   localparam int TIME_W  = 32;
   localparam int AGE_W   = 16;
   localparam int COUNT_W = 5;
   localparam int ENTRY_W = TICK_W + TIME_W;

   localparam logic [1:0] REQ_STORE  = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_EXPIRE = 2'd2;

   localparam logic [AGE_W-1:0] MAX_AGE_RESET = AGE_W'(1000);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STORE_RD,
      ST_STORE_WR,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               found;
      logic [TICK_W-1:0]  found_tick;
      logic [TIME_W-1:0]  found_time_ms;
      logic               in_window;
      logic [COUNT_W-1:0] valid_count;
   } result_type;

endpackage

`default_nettype wire

FILE: src/thrl_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module thrl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/thrl_seq.sv
// Sequencer that stores entries, scans the ring for lookups and expiry, and keeps the bookkeeping.
`default_nettype none

module thrl_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [1:0]                    in_type,
   input  wire logic [thrl_pkg::TICK_W-1:0]   in_tick,
   input  wire logic [thrl_pkg::TIME_W-1:0]   in_now_ms,
   input  wire logic [thrl_pkg::AGE_W-1:0]    max_age_ms,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output thrl_pkg::result_type               out_result,
   output logic                               ram_wr_en,
   output logic [thrl_pkg::IDX_W-1:0]         ram_wr_addr,
   output logic [thrl_pkg::ENTRY_W-1:0]       ram_wr_data,
   output logic                               ram_rd_en,
   output logic [thrl_pkg::IDX_W-1:0]         ram_rd_addr,
   input  wire logic [thrl_pkg::ENTRY_W-1:0]  ram_rd_data
);

   thrl_pkg::state_type                 state_ff, state_in;
   logic [thrl_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic                                chk_valid_ff, chk_valid_in;
   logic [thrl_pkg::IDX_W-1:0]          chk_idx_ff, chk_idx_in;
   logic [1:0]                          op_ff, op_in;
   logic [thrl_pkg::TICK_W-1:0]         tick_ff, tick_in;
   logic [thrl_pkg::TIME_W-1:0]         time_ff, time_in;
   logic                                found_ff, found_in;
   logic [thrl_pkg::TICK_W-1:0]         best_tick_ff, best_tick_in;
   logic [thrl_pkg::TIME_W-1:0]         best_time_ff, best_time_in;
   logic [thrl_pkg::DEPTH-1:0]          valid_ff, valid_in;
   logic [thrl_pkg::IDX_W-1:0]          pos_ff, pos_in;
   logic [thrl_pkg::LIVE_W-1:0]         live_ff, live_in;
   logic [thrl_pkg::TICK_W-1:0]         oldest_ff, oldest_in;
   logic [thrl_pkg::TICK_W-1:0]         newest_ff, newest_in;

   logic [thrl_pkg::TICK_W-1:0]         rd_tick;
   logic [thrl_pkg::TIME_W-1:0]         rd_time;
   logic [thrl_pkg::IDX_W-1:0]          next_pos;
   logic [thrl_pkg::TIME_W-1:0]         age_ext;
   logic [thrl_pkg::TIME_W-1:0]         cutoff;
   logic [thrl_pkg::LIVE_W-1:0]         live_new;

   assign rd_tick = ram_rd_data[thrl_pkg::ENTRY_W-1:thrl_pkg::TIME_W];
   assign rd_time = ram_rd_data[thrl_pkg::TIME_W-1:0];
   assign next_pos = (pos_ff == thrl_pkg::IDX_W'(thrl_pkg::DEPTH - 1)) ?
                     '0 : thrl_pkg::IDX_W'(pos_ff + 1'b1);
   assign age_ext = thrl_pkg::TIME_W'(max_age_ms);
   assign cutoff  = (in_now_ms >= age_ext) ? (in_now_ms - age_ext) : '0;
   assign live_new = (!valid_ff[pos_ff] && (live_ff < thrl_pkg::LIVE_W'(thrl_pkg::DEPTH))) ?
                     thrl_pkg::LIVE_W'(live_ff + 1'b1) : live_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= thrl_pkg::ST_IDLE;
         chk_valid_ff <= 1'b0;
         valid_ff     <= '0;
         pos_ff       <= '0;
         live_ff      <= '0;
         oldest_ff    <= '0;
         newest_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         valid_ff     <= valid_in;
         pos_ff       <= pos_in;
         live_ff      <= live_in;
         oldest_ff    <= oldest_in;
         newest_ff    <= newest_in;
      end
      idx_ff       <= idx_in;
      chk_idx_ff   <= chk_idx_in;
      op_ff        <= op_in;
      tick_ff      <= tick_in;
      time_ff      <= time_in;
      found_ff     <= found_in;
      best_tick_ff <= best_tick_in;
      best_time_ff <= best_time_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      op_in        = op_ff;
      tick_in      = tick_ff;
      time_in      = time_ff;
      found_in     = found_ff;
      best_tick_in = best_tick_ff;
      best_time_in = best_time_ff;
      valid_in     = valid_ff;
      pos_in       = pos_ff;
      live_in      = live_ff;
      oldest_in    = oldest_ff;
      newest_in    = newest_ff;
      in_ready     = 1'b0;
      out_valid    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pos_ff;
      ram_wr_data  = {tick_ff, time_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff;

      // The entry read in the previous cycle is judged here.
      if (chk_valid_ff && valid_ff[chk_idx_ff]) begin
         if (op_ff == thrl_pkg::REQ_LOOKUP && rd_tick <= tick_ff &&
             (!found_ff || rd_tick > best_tick_ff)) begin
            found_in     = 1'b1;
            best_tick_in = rd_tick;
            best_time_in = rd_time;
         end
         if (op_ff == thrl_pkg::REQ_EXPIRE && rd_time < time_ff) begin
            valid_in[chk_idx_ff] = 1'b0;
            live_in = thrl_pkg::LIVE_W'(live_ff - 1'b1);
         end
      end

      case (state_ff)
         thrl_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               op_in        = in_type;
               tick_in      = in_tick;
               time_in      = (in_type == thrl_pkg::REQ_EXPIRE) ? cutoff : in_now_ms;
               found_in     = 1'b0;
               best_tick_in = '0;
               best_time_in = '0;
               idx_in       = '0;
               if (in_type == thrl_pkg::REQ_STORE) begin
                  state_in = thrl_pkg::ST_STORE_RD;
               end else if (in_type == thrl_pkg::REQ_LOOKUP ||
                            in_type == thrl_pkg::REQ_EXPIRE) begin
                  state_in = thrl_pkg::ST_SCAN;
               end else begin
                  state_in = thrl_pkg::ST_DONE;
               end
            end
         end
         thrl_pkg::ST_STORE_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = next_pos;
            state_in    = thrl_pkg::ST_STORE_WR;
         end
         thrl_pkg::ST_STORE_WR: begin
            ram_wr_en        = 1'b1;
            valid_in[pos_ff] = 1'b1;
            live_in          = live_new;
            newest_in        = tick_ff;
            if (live_new == thrl_pkg::LIVE_W'(thrl_pkg::DEPTH)) begin
               oldest_in = rd_tick;
            end else if (live_new == thrl_pkg::LIVE_W'(1)) begin
               oldest_in = tick_ff;
            end
            pos_in   = next_pos;
            state_in = thrl_pkg::ST_DONE;
         end
         thrl_pkg::ST_SCAN: begin
            ram_rd_en    = 1'b1;
            ram_rd_addr  = idx_ff;
            chk_valid_in = 1'b1;
            chk_idx_in   = idx_ff;
            idx_in       = thrl_pkg::IDX_W'(idx_ff + 1'b1);
            if (idx_ff == thrl_pkg::IDX_W'(thrl_pkg::DEPTH - 1)) begin
               state_in = thrl_pkg::ST_DRAIN;
            end
         end
         thrl_pkg::ST_DRAIN: begin
            state_in = thrl_pkg::ST_DONE;
         end
         thrl_pkg::ST_DONE: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = thrl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = thrl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_result.found         = found_ff;
      out_result.found_tick    = best_tick_ff;
      out_result.found_time_ms = best_time_ff;
      out_result.in_window     = (op_ff == thrl_pkg::REQ_LOOKUP) && (tick_ff >= oldest_ff) &&
                                 (tick_ff <= newest_ff) && (live_ff != '0);
      out_result.valid_count   = thrl_pkg::COUNT_W'(live_ff);
   end

endmodule

`default_nettype wire

FILE: src/tick_history_ring_lookup.sv
// Top level of the tick history ring: configuration register, entry RAM, sequencer, result register.
//
// Usage: request beats arrive on req_valid/req_ready with req_type (store, lookup, expire),
// req_tick and req_now_ms. Each request gives exactly one response beat on
// rsp_valid/rsp_ready. The age limit is written through csr_wr_en/csr_wr_data while idle.
// One request is in flight at a time. A store reads the next slot's tick and then writes
// the entry back before its response. A lookup or an expire scans all DEPTH entries,
// reading one RAM entry per cycle through its single read port, then passes a drain
// state. An unused request code goes straight to its response. The next request can
// be accepted in the cycle after the response is loaded into the output register.
// Reset empties the ring at once (valid marks cleared), sets the age limit to 1000 ms
// and drops any pending response; no clearing pass is needed.
// The response sits in an output register; while the receiver stalls, a further request
// is still accepted and processed, and its result waits until the register is free.
`default_nettype none

module tick_history_ring_lookup (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_type,
   input  wire logic [thrl_pkg::TICK_W-1:0]         req_tick,
   input  wire logic [thrl_pkg::TIME_W-1:0]         req_now_ms,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_found,
   output logic [thrl_pkg::TICK_W-1:0]              rsp_found_tick,
   output logic [thrl_pkg::TIME_W-1:0]              rsp_found_time_ms,
   output logic                                     rsp_in_window,
   output logic [thrl_pkg::COUNT_W-1:0]             rsp_valid_count,
   input  wire logic                                csr_wr_en,
   input  wire logic [thrl_pkg::AGE_W-1:0]          csr_wr_data
);

   logic [thrl_pkg::AGE_W-1:0]   max_age_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   thrl_pkg::result_type         rsp_ff, rsp_in;
   thrl_pkg::result_type         seq_result;
   logic                         seq_valid;
   logic                         seq_ready;
   logic                         ram_wr_en;
   logic [thrl_pkg::IDX_W-1:0]   ram_wr_addr;
   logic [thrl_pkg::ENTRY_W-1:0] ram_wr_data;
   logic                         ram_rd_en;
   logic [thrl_pkg::IDX_W-1:0]   ram_rd_addr;
   logic [thrl_pkg::ENTRY_W-1:0] ram_rd_data;

   thrl_ram #(
      .WIDTH (thrl_pkg::ENTRY_W),
      .DEPTH (thrl_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   thrl_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_type     (req_type),
      .in_tick     (req_tick),
      .in_now_ms   (req_now_ms),
      .max_age_ms  (max_age_ff),
      .out_valid   (seq_valid),
      .out_ready   (seq_ready),
      .out_result  (seq_result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   assign seq_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (seq_ready) begin
         rsp_valid_in = seq_valid;
         if (seq_valid) begin
            rsp_in = seq_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff   <= thrl_pkg::MAX_AGE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_age_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_ff.found;
   assign rsp_found_tick    = rsp_ff.found_tick;
   assign rsp_found_time_ms = rsp_ff.found_time_ms;
   assign rsp_in_window     = rsp_ff.in_window;
   assign rsp_valid_count   = rsp_ff.valid_count;

`ifndef ASSERT_OFF
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another was in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_valid_count <= thrl_pkg::COUNT_W'(thrl_pkg::DEPTH))
      else $error("valid count exceeds ring depth");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_found_tick == '0 && rsp_found_time_ms == '0)
      else $error("miss carries a nonzero entry");

   a_window_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_window |-> rsp_valid_count != '0)
      else $error("window hit reported on an empty ring");
`endif

endmodule

`default_nettype wire
